// ----- rtl/pnorm_pkg.sv -----
// shared constants, codes and types of the path normalizer
`default_nettype none

package pnorm_pkg;

  // default sizes
  localparam int unsigned PATH_BYTES_DEF = 256;
  localparam int unsigned NAME_LIMIT_DEF = 63;

  // characters
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [15:0] COMP_DOTDOT = {CHAR_DOT, CHAR_DOT};

  // request function codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_BUSY = 2'd1;
  localparam logic [1:0] STATUS_ERR  = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEP,
    ST_WALK,
    ST_RDAT,
    ST_HOLD
  } pnorm_state_e;

  // one result item
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_length;
    logic [7:0] read_data;
  } pnorm_result_t;

endpackage

`default_nettype wire

// ----- rtl/pnorm_if.sv -----
// request and response channel interfaces of the path normalizer
`default_nettype none

interface pnorm_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] path_byte;
  logic [7:0] read_index;

  modport source (output valid, func, path_byte, read_index, input ready);
  modport sink (input valid, func, path_byte, read_index, output ready);
endinterface

interface pnorm_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_length;
  logic [7:0] read_data;

  modport source (output valid, status, out_length, read_data, input ready);
  modport sink (input valid, status, out_length, read_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/path_normalizer_unit.sv -----
// top level of the path normalizer: request sequencer, path state and result register
// push: result registered; a new request is taken every cycle while the response is not stalled,
//   except the first byte of a name after a separator, which needs a second store write (one write port)
// read: the store read port is registered, so the result is formed in ST_RDAT from its data
// '..': steps back one stored byte at a time through the store read port (ST_WALK)
// reset: async, active low; path state returns to "/" with no error, store is not cleared
`default_nettype none

module path_normalizer_unit #(
  parameter int unsigned PATH_BYTES = pnorm_pkg::PATH_BYTES_DEF,
  parameter int unsigned NAME_LIMIT = pnorm_pkg::NAME_LIMIT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pnorm_req_if.sink    req_i,
  pnorm_rsp_if.source  rsp_o,
  input  logic         cfg_we_i,
  input  logic [8:0]   cfg_wdata_i
);

  localparam int unsigned AW      = $clog2(PATH_BYTES);
  localparam int unsigned CW      = (AW + 1 > 10) ? AW + 1 : 10;
  localparam int unsigned CLW     = $clog2(NAME_LIMIT + 2);
  localparam int unsigned CAP_MAX = (PATH_BYTES < 256) ? PATH_BYTES : 256;

  pnorm_pkg::pnorm_state_e state_q, state_d;

  logic [8:0]     out_len_q, out_len_d;
  logic           last_slash_q, last_slash_d;
  logic [CLW-1:0] comp_len_q, comp_len_d;
  logic [15:0]    comp_ft_q, comp_ft_d;
  logic           err_q, err_d;
  logic           fin_q, fin_d;
  logic [8:0]     cap_q, cap_d;
  logic           term_q, term_d;
  logic [7:0]     byte_q, byte_d;
  logic [7:0]     idx_q, idx_d;

  logic                     rsp_valid_q, rsp_valid_d;
  pnorm_pkg::pnorm_result_t rsp_q, rsp_d;
  pnorm_pkg::pnorm_result_t hold_q, hold_d;
  pnorm_pkg::pnorm_result_t res;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // path state as a push sees it: a finished path restarts first
  logic [8:0]     v_ol;
  logic           v_ls;
  logic [CLW-1:0] v_cl;
  logic [15:0]    v_cft;
  logic           v_err;

  assign v_ol  = fin_q ? 9'd1 : out_len_q;
  assign v_ls  = fin_q | last_slash_q;
  assign v_cl  = fin_q ? '0 : comp_len_q;
  assign v_cft = fin_q ? '0 : comp_ft_q;
  assign v_err = !fin_q && err_q;

  // pending component classification
  logic          c_none, c_dot, c_dd, c_name, sep, c_bad;
  logic [CW-1:0] c_sum;
  logic [8:0]    ol_start;

  assign c_none   = (v_cl == '0);
  assign c_dot    = (v_cl == CLW'(1)) && (v_cft[7:0] == pnorm_pkg::CHAR_DOT);
  assign c_dd     = (v_cl == CLW'(2)) && (v_cft == pnorm_pkg::COMP_DOTDOT);
  assign c_name   = !c_none && !c_dot && !c_dd;
  assign sep      = !v_ls;
  assign c_sum    = CW'(v_ol) + CW'(sep) + CW'(v_cl);
  assign c_bad    = (v_cl > CLW'(NAME_LIMIT)) || (c_sum >= CW'(cap_q));
  assign ol_start = ((v_ol > 9'd1) && v_ls) ? v_ol - 9'd1 : v_ol;

  // component close without the walk
  logic [8:0] cl_ol;
  logic       cl_ls;
  logic       cl_err;

  always_comb begin
    cl_ol  = v_ol;
    cl_ls  = v_ls;
    cl_err = v_err;
    if (c_dd) begin
      cl_ol = ol_start;
      cl_ls = 1'b1;
    end else if (c_name) begin
      if (c_bad) begin
        cl_err = 1'b1;
      end else begin
        cl_ol = c_sum[8:0];
        cl_ls = 1'b0;
      end
    end
  end

  // request decode
  logic acc, is_read, p_term, p_slash, push_live, closing, start_walk, sep_wr;

  assign acc        = req_i.valid && (state_q == pnorm_pkg::ST_IDLE);
  assign is_read    = (req_i.func == pnorm_pkg::FUNC_READ);
  assign p_term     = (req_i.path_byte == pnorm_pkg::CHAR_NUL);
  assign p_slash    = (req_i.path_byte == pnorm_pkg::CHAR_SLASH);
  assign push_live  = acc && !is_read && !v_err;
  assign closing    = push_live && (p_term || p_slash);
  assign start_walk = closing && c_dd && (ol_start > 9'd1);
  assign sep_wr     = push_live && !p_term && !p_slash && c_none && sep;

  // backtrack walk over the store
  logic       in_walk, w_slash, w_done;
  logic [8:0] w_ol;

  assign in_walk = (state_q == pnorm_pkg::ST_WALK);
  assign w_slash = (mem_rdata == pnorm_pkg::CHAR_SLASH);
  assign w_done  = w_slash || (out_len_q <= 9'd2);
  assign w_ol    = w_slash ? out_len_q : out_len_q - 9'd1;

  // terminator handling after the close
  logic [8:0] pc_ol, t_ol;
  logic       pc_ls, pc_err, t_err, term_now;

  assign pc_ol    = in_walk ? w_ol : (v_err ? v_ol : cl_ol);
  assign pc_ls    = in_walk ? 1'b1 : (v_err ? v_ls : cl_ls);
  assign pc_err   = in_walk ? err_q : (v_err | cl_err);
  assign t_err    = pc_err || (cap_q < 9'd2);
  assign t_ol     = (!t_err && (pc_ol > 9'd1) && pc_ls) ? pc_ol - 9'd1 : pc_ol;
  assign term_now = (state_q == pnorm_pkg::ST_IDLE) ? p_term : (in_walk && term_q);

  // result production
  logic res_fire, out_free;
  logic [CW-1:0] s_addr;

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign s_addr   = CW'(out_len_q) + CW'(1);
  assign res_fire = (acc && !is_read && !start_walk && !sep_wr)
                 || (in_walk && w_done)
                 || (state_q == pnorm_pkg::ST_SEP)
                 || (state_q == pnorm_pkg::ST_RDAT);

  always_comb begin
    res = '0;
    if (state_q == pnorm_pkg::ST_RDAT) begin
      res.status = fin_q ? (err_q ? pnorm_pkg::STATUS_ERR : pnorm_pkg::STATUS_OK)
                         : pnorm_pkg::STATUS_BUSY;
      if (fin_q && !err_q) begin
        res.out_length = out_len_q[7:0];
      end
      if ({1'b0, idx_q} < out_len_q) begin
        res.read_data = (idx_q == 8'd0) ? pnorm_pkg::CHAR_SLASH : mem_rdata;
      end
    end else if (term_now) begin
      res.status = t_err ? pnorm_pkg::STATUS_ERR : pnorm_pkg::STATUS_OK;
      if (!t_err) begin
        res.out_length = t_ol[7:0];
      end
    end else begin
      res.status = pnorm_pkg::STATUS_BUSY;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pnorm_pkg::ST_IDLE: begin
        if (acc) begin
          if (is_read) begin
            state_d = pnorm_pkg::ST_RDAT;
          end else if (start_walk) begin
            state_d = pnorm_pkg::ST_WALK;
          end else if (sep_wr) begin
            state_d = pnorm_pkg::ST_SEP;
          end else begin
            state_d = out_free ? pnorm_pkg::ST_IDLE : pnorm_pkg::ST_HOLD;
          end
        end
      end
      pnorm_pkg::ST_SEP, pnorm_pkg::ST_RDAT: begin
        state_d = out_free ? pnorm_pkg::ST_IDLE : pnorm_pkg::ST_HOLD;
      end
      pnorm_pkg::ST_WALK: begin
        if (w_done) begin
          state_d = out_free ? pnorm_pkg::ST_IDLE : pnorm_pkg::ST_HOLD;
        end
      end
      pnorm_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = pnorm_pkg::ST_IDLE;
        end
      end
      default: state_d = pnorm_pkg::ST_IDLE;
    endcase
  end

  // path state update and store accesses
  always_comb begin
    out_len_d    = out_len_q;
    last_slash_d = last_slash_q;
    comp_len_d   = comp_len_q;
    comp_ft_d    = comp_ft_q;
    err_d        = err_q;
    fin_d        = fin_q;
    term_d       = term_q;
    byte_d       = byte_q;
    idx_d        = idx_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = pnorm_pkg::CHAR_SLASH;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    case (state_q)
      pnorm_pkg::ST_IDLE: begin
        if (acc && is_read) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(req_i.read_index);
          idx_d     = req_i.read_index;
        end else if (acc) begin
          out_len_d    = v_ol;
          last_slash_d = v_ls;
          comp_len_d   = v_cl;
          comp_ft_d    = v_cft;
          err_d        = v_err;
          fin_d        = 1'b0;
          term_d       = p_term;
          if (closing) begin
            out_len_d    = cl_ol;
            last_slash_d = cl_ls;
            err_d        = cl_err;
            comp_len_d   = '0;
            comp_ft_d    = '0;
            if (start_walk) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(ol_start - 9'd1);
            end
          end else if (push_live) begin
            if (sep_wr) begin
              // separator first, name byte in the next cycle
              mem_we    = 1'b1;
              mem_waddr = AW'(v_ol);
              byte_d    = req_i.path_byte;
            end else begin
              mem_we    = (c_sum < CW'(PATH_BYTES));
              mem_waddr = AW'(c_sum);
              mem_wdata = req_i.path_byte;
              if (c_none) begin
                comp_ft_d = {8'h00, req_i.path_byte};
              end else if (v_cl == CLW'(1)) begin
                comp_ft_d = {req_i.path_byte, v_cft[7:0]};
              end
              if (v_cl <= CLW'(NAME_LIMIT)) begin
                comp_len_d = v_cl + CLW'(1);
              end
            end
          end
          if (p_term && !start_walk) begin
            out_len_d = t_ol;
            err_d     = t_err;
            fin_d     = 1'b1;
          end
        end
      end
      pnorm_pkg::ST_SEP: begin
        mem_we     = (s_addr < CW'(PATH_BYTES));
        mem_waddr  = AW'(s_addr);
        mem_wdata  = byte_q;
        comp_len_d = CLW'(1);
        comp_ft_d  = {8'h00, byte_q};
      end
      pnorm_pkg::ST_WALK: begin
        if (!w_done) begin
          // step back one byte and fetch the one before it
          out_len_d = out_len_q - 9'd1;
          mem_re    = 1'b1;
          mem_raddr = AW'(out_len_q - 9'd2);
        end else begin
          out_len_d    = w_ol;
          last_slash_d = 1'b1;
          if (term_q) begin
            out_len_d = t_ol;
            err_d     = t_err;
            fin_d     = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // capacity in effect
  always_comb begin
    cap_d = cap_q;
    if (cfg_we_i) begin
      cap_d = (cfg_wdata_i > 9'(CAP_MAX)) ? 9'(CAP_MAX) : cfg_wdata_i;
    end
  end

  // result register with a hold slot
  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    hold_d      = hold_q;
    if (res_fire) begin
      if (out_free) begin
        rsp_valid_d = 1'b1;
        rsp_d       = res;
      end else begin
        hold_d = res;
      end
    end
    if ((state_q == pnorm_pkg::ST_HOLD) && out_free) begin
      rsp_valid_d = 1'b1;
      rsp_d       = hold_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pnorm_pkg::ST_IDLE;
      out_len_q    <= 9'd1;
      last_slash_q <= 1'b1;
      comp_len_q   <= '0;
      comp_ft_q    <= '0;
      err_q        <= 1'b0;
      fin_q        <= 1'b0;
      cap_q        <= 9'(CAP_MAX);
      term_q       <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_len_q    <= out_len_d;
      last_slash_q <= last_slash_d;
      comp_len_q   <= comp_len_d;
      comp_ft_q    <= comp_ft_d;
      err_q        <= err_d;
      fin_q        <= fin_d;
      cap_q        <= cap_d;
      term_q       <= term_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    idx_q  <= idx_d;
    rsp_q  <= rsp_d;
    hold_q <= hold_d;
  end

  pnorm_store #(
    .DEPTH (PATH_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ports
  assign req_i.ready      = (state_q == pnorm_pkg::ST_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_q.status;
  assign rsp_o.out_length = rsp_q.out_length;
  assign rsp_o.read_data  = rsp_q.read_data;

endmodule

`default_nettype wire

// ----- rtl/pnorm_store.sv -----
// byte store of the normalized path: one write port, one registered read port
`default_nettype none

module pnorm_store #(
  parameter int unsigned DEPTH = pnorm_pkg::PATH_BYTES_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] store_mem [DEPTH];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= store_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/pnorm_checker.sv -----
// port-level checks of the path normalizer and their bind to the top level
`default_nettype none

module pnorm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [1:0] rsp_status_i,
  input logic [7:0] rsp_length_i
);

  // a stalled response keeps its content
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_length_i))
    else $error("stalled response changed");

  // a request taken while the response slot is blocked stops further requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && rsp_valid_i && !rsp_ready_i |=> !req_ready_i)
    else $error("request taken while the response slot is full");

  // length only comes with a good status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != pnorm_pkg::STATUS_OK) |-> rsp_length_i == 8'd0)
    else $error("length reported without a complete path");

  // a complete path holds at least the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == pnorm_pkg::STATUS_OK) |-> rsp_length_i != 8'd0)
    else $error("complete path with zero length");

endmodule

bind path_normalizer_unit pnorm_checker u_pnorm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_length_i (rsp_o.out_length)
);

`default_nettype wire
